/* hdl/hxfr_pkg.sv */
// Package for the header/XOR frame receiver: command codes, status and
// record kind codes, frame length and the result beat type.
// No dependencies.
package hxfr_pkg;

   localparam logic [7:0] HEADER_RESET = 8'hAA;

   localparam logic [7:0] CMD_OFF     = 8'hB0;
   localparam logic [7:0] CMD_ON      = 8'hB1;
   localparam logic [7:0] CMD_TIMEOUT = 8'hB2;
   localparam logic [7:0] CMD_FLASH   = 8'hB3;
   localparam logic [7:0] CMD_MODULE  = 8'hB4;
   localparam logic [7:0] CMD_BRIGHT  = 8'hB5;

   // Bytes per frame: header, seq, id, command, argument, checksum.
   localparam int unsigned FRAME_LEN = 6;

   localparam logic [1:0] STATUS_GOOD      = 2'd0;
   localparam logic [1:0] STATUS_BAD       = 2'd1;
   localparam logic [1:0] STATUS_ABANDONED = 2'd2;

   localparam logic [2:0] KIND_NONE    = 3'd0;
   localparam logic [2:0] KIND_LAMP    = 3'd1;
   localparam logic [2:0] KIND_TIMEOUT = 3'd2;
   localparam logic [2:0] KIND_BRIGHT  = 3'd3;
   localparam logic [2:0] KIND_MODULE  = 3'd4;
   localparam logic [2:0] KIND_OTHER   = 3'd5;

   typedef struct packed {
      logic [1:0] frame_status;
      logic [7:0] seq_number;
      logic [7:0] lamp_id;
      logic [7:0] command_code;
      logic [7:0] argument;
      logic [2:0] record_kind;
      logic       all_off;
   } rsp_type;

endpackage

/* hdl/header_xor_frame_receiver.sv */
// Header/XOR frame receiver, top level. Depends on hxfr_pkg. The result beat
// for the byte that closes or abandons a frame is registered in the result
// register, or the skid register while one waits. Throughput: one byte per
// cycle while req_ready is high. A two-entry output stage (result register
// plus skid register) keeps req_ready high while one result waits. Synchronous
// active-high reset clears frame state and lamp table and loads header 0xAA.
module header_xor_frame_receiver
   import hxfr_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   // configuration
   input  logic       csr_we,
   input  logic [7:0] csr_wdata,
   // received bytes
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_rx_byte,
   // frame reports
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [1:0] rsp_frame_status,
   output logic [7:0] rsp_seq_number,
   output logic [7:0] rsp_lamp_id,
   output logic [7:0] rsp_command_code,
   output logic [7:0] rsp_argument,
   output logic [2:0] rsp_record_kind,
   output logic       rsp_all_off
);

   // ------------------------------------------------------------------
   // State
   // ------------------------------------------------------------------
   logic [7:0] header_ff;
   logic       in_frame_ff,  in_frame_in;
   logic [2:0] count_ff,     count_in;     // bytes taken so far, header included
   logic [7:0] xor_ff,       xor_in;
   logic [7:0] seq_ff,       seq_in;
   logic [7:0] id_ff,        id_in;
   logic [7:0] cmd_ff,       cmd_in;
   logic [7:0] arg_ff,       arg_in;
   // Only lamps 1 and 2 feed all_off; other table entries are never read,
   // so hold just those two entries.
   logic [7:0] lamp1_ff,     lamp1_in;
   logic [7:0] lamp2_ff,     lamp2_in;

   // Output stage
   logic       out_valid_ff, out_valid_in;
   rsp_type    out_ff,       out_in;
   logic       skid_valid_ff, skid_valid_in;
   rsp_type    skid_ff,      skid_in;

   logic       accept;
   logic       pop;
   logic       emit;
   rsp_type    result;

   logic       is_header;
   logic       is_lamp_cmd;
   logic [7:0] next_lamp1;
   logic [7:0] next_lamp2;

   // Accept while the skid slot is free: a waiting result never blocks input.
   assign req_ready = !skid_valid_ff;
   assign accept    = req_valid && req_ready;
   assign pop       = out_valid_ff && rsp_ready;

   assign is_header   = (req_rx_byte == header_ff);
   assign is_lamp_cmd = (cmd_ff == CMD_OFF) || (cmd_ff == CMD_ON) || (cmd_ff == CMD_FLASH);

   // Table contents after a good lamp-state frame; the id is always inside
   // the table for lamps 1 and 2, so no range check is needed here.
   assign next_lamp1 = (is_lamp_cmd && id_ff == 8'd1) ? cmd_ff : lamp1_ff;
   assign next_lamp2 = (is_lamp_cmd && id_ff == 8'd2) ? cmd_ff : lamp2_ff;

   // ------------------------------------------------------------------
   // Frame assembly: one byte per accepted beat
   // ------------------------------------------------------------------
   always_comb begin
      in_frame_in = in_frame_ff;
      count_in    = count_ff;
      xor_in      = xor_ff;
      seq_in      = seq_ff;
      id_in       = id_ff;
      cmd_in      = cmd_ff;
      arg_in      = arg_ff;
      lamp1_in    = lamp1_ff;
      lamp2_in    = lamp2_ff;
      emit        = 1'b0;

      // Report carries the bytes collected so far; unreceived ones are zero.
      result.frame_status = STATUS_ABANDONED;
      result.seq_number   = seq_ff;
      result.lamp_id      = id_ff;
      result.command_code = cmd_ff;
      result.argument     = arg_ff;
      result.record_kind  = KIND_NONE;
      result.all_off      = 1'b0;

      if (accept) begin
         if (is_header) begin
            // A header always restarts; abandon any open frame.
            emit        = in_frame_ff;
            in_frame_in = 1'b1;
            count_in    = 3'd1;
            xor_in      = req_rx_byte;
            seq_in      = '0;
            id_in       = '0;
            cmd_in      = '0;
            arg_in      = '0;
         end else if (in_frame_ff) begin
            if (count_ff < 3'(FRAME_LEN - 1)) begin
               // Body byte: store it and fold it into the checksum.
               case (count_ff)
                  3'd1:    seq_in = req_rx_byte;
                  3'd2:    id_in  = req_rx_byte;
                  3'd3:    cmd_in = req_rx_byte;
                  default: arg_in = req_rx_byte;
               endcase
               xor_in   = xor_ff ^ req_rx_byte;
               count_in = count_ff + 3'd1;
            end else begin
               // Checksum byte: close the frame and report it.
               emit = 1'b1;
               if (xor_ff == req_rx_byte) begin
                  result.frame_status = STATUS_GOOD;
                  if (is_lamp_cmd) begin
                     result.record_kind = KIND_LAMP;
                     lamp1_in = next_lamp1;
                     lamp2_in = next_lamp2;
                     result.all_off = (next_lamp1 == CMD_OFF) && (next_lamp2 == CMD_OFF);
                  end else if (cmd_ff == CMD_TIMEOUT) begin
                     result.record_kind = KIND_TIMEOUT;
                  end else if (cmd_ff == CMD_BRIGHT) begin
                     result.record_kind = KIND_BRIGHT;
                  end else if (cmd_ff == CMD_MODULE) begin
                     result.record_kind = KIND_MODULE;
                  end else begin
                     result.record_kind = KIND_OTHER;
                  end
               end else begin
                  result.frame_status = STATUS_BAD;
               end
               in_frame_in = 1'b0;
               count_in    = '0;
               xor_in      = '0;
               seq_in      = '0;
               id_in       = '0;
               cmd_in      = '0;
               arg_in      = '0;
            end
         end
         // Otherwise: byte outside a frame, drop it.
      end
   end

   // ------------------------------------------------------------------
   // Output stage: result register backed by one skid register
   // ------------------------------------------------------------------
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;

      if (skid_valid_ff) begin
         // Input is stalled; advance the skid entry once the head drains.
         if (pop) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (emit) begin
         if (!out_valid_ff || pop) begin
            out_in       = result;
            out_valid_in = 1'b1;
         end else begin
            skid_in       = result;
            skid_valid_in = 1'b1;
         end
      end else if (pop) begin
         out_valid_in = 1'b0;
      end
   end

   // ------------------------------------------------------------------
   // Registers
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         header_ff     <= HEADER_RESET;
         in_frame_ff   <= 1'b0;
         count_ff      <= '0;
         xor_ff        <= '0;
         seq_ff        <= '0;
         id_ff         <= '0;
         cmd_ff        <= '0;
         arg_ff        <= '0;
         lamp1_ff      <= '0;
         lamp2_ff      <= '0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            header_ff <= csr_wdata;
         end
         in_frame_ff   <= in_frame_in;
         count_ff      <= count_in;
         xor_ff        <= xor_in;
         seq_ff        <= seq_in;
         id_ff         <= id_in;
         cmd_ff        <= cmd_in;
         arg_ff        <= arg_in;
         lamp1_ff      <= lamp1_in;
         lamp2_ff      <= lamp2_in;
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   // Payload registers hold whatever they last captured.
   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_frame_status = out_ff.frame_status;
   assign rsp_seq_number   = out_ff.seq_number;
   assign rsp_lamp_id      = out_ff.lamp_id;
   assign rsp_command_code = out_ff.command_code;
   assign rsp_argument     = out_ff.argument;
   assign rsp_record_kind  = out_ff.record_kind;
   assign rsp_all_off      = out_ff.all_off;

endmodule
